// ===== hdl/usan_pkg.sv =====
// shared types and constants for the utf-8 to cesu-8 sanitizer
`default_nettype none

package usan_pkg;

	localparam logic [7:0] REPL_BYTE0 = 8'hEF;
	localparam logic [7:0] REPL_BYTE1 = 8'hBF;
	localparam logic [7:0] REPL_BYTE2 = 8'hBD;

	// byte position inside one replacement character
	localparam logic [1:0] REPL_POS0 = 2'd0;
	localparam logic [1:0] REPL_POS1 = 2'd1;
	localparam logic [1:0] REPL_POS2 = 2'd2;

	localparam int LIT_MAX = 3;

	// output work for one input byte: replacement characters first, then literal bytes
	typedef struct packed {
		logic [1:0]                nrep;
		logic [1:0]                nlit;
		logic [LIT_MAX-1:0][7:0]   lit;
		logic                      last;
	} usan_desc_t;

endpackage

`default_nettype wire

// ===== hdl/usan_parse.sv =====
// sequence parser: decodes one input byte against the open sequence into output work
`default_nettype none

module usan_parse (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          in_byte,
	input  wire logic                in_last,
	output usan_pkg::usan_desc_t     desc,
	output logic                     push
);
	import usan_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_EXPECT = 3'b010,
		MODE_SKIP   = 3'b100
	} mode_t;

	mode_t       mode_q, mode_d;
	logic        seq3_q, seq3_d;
	logic [1:0]  conts_q, conts_d;
	logic [7:0]  held0_q, held0_d;
	logic [7:0]  held1_q, held1_d;

	logic        is_cont;
	logic        do_fresh;
	logic        overlong;
	logic [1:0]  nrep;
	logic [1:0]  nlit;
	logic [LIT_MAX-1:0][7:0] lit;

	assign is_cont = (in_byte[7:6] == 2'b10);

	always_comb begin
		mode_d   = mode_q;
		seq3_d   = seq3_q;
		conts_d  = conts_q;
		held0_d  = held0_q;
		held1_d  = held1_q;
		nrep     = 2'd0;
		nlit     = 2'd0;
		lit      = '0;
		do_fresh = 1'b0;
		overlong = seq3_q ? (held0_q[3:0] == 4'd0 && !held1_q[5]) : (held0_q[4:1] == 4'd0);

		unique case (mode_q)
			MODE_SKIP: begin
				if (is_cont) begin
					if (conts_q == 2'd2) begin
						mode_d  = MODE_IDLE;
						conts_d = 2'd0;
					end else begin
						conts_d = conts_q + 2'd1;
					end
				end else begin
					do_fresh = 1'b1;
				end
			end
			MODE_EXPECT: begin
				if (is_cont) begin
					if (!seq3_q || conts_q[0]) begin
						// sequence complete
						if (overlong) begin
							nrep = seq3_q ? 2'd3 : 2'd2;
						end else if (seq3_q) begin
							lit  = {in_byte, held1_q, held0_q};
							nlit = 2'd3;
						end else begin
							lit[0] = held0_q;
							lit[1] = in_byte;
							nlit   = 2'd2;
						end
						mode_d  = MODE_IDLE;
						conts_d = 2'd0;
					end else begin
						held1_d = in_byte;
						conts_d = 2'd1;
						if (in_last) begin
							nrep    = 2'd2;
							mode_d  = MODE_IDLE;
							conts_d = 2'd0;
						end
					end
				end else begin
					// broken sequence: one replacement per buffered byte, then reparse
					nrep     = conts_q[0] ? 2'd2 : 2'd1;
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		if (do_fresh) begin
			mode_d  = MODE_IDLE;
			conts_d = 2'd0;
			if (!in_byte[7]) begin
				lit[0] = in_byte;
				nlit   = 2'd1;
			end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110) begin
				if (in_last) begin
					nrep = nrep + 2'd1;
				end else begin
					mode_d  = MODE_EXPECT;
					seq3_d  = (in_byte[7:5] != 3'b110);
					held0_d = in_byte;
				end
			end else if (in_byte[7:3] == 5'b11110) begin
				nrep = nrep + 2'd1;
				if (!in_last) begin
					mode_d = MODE_SKIP;
				end
			end else begin
				nrep = nrep + 2'd1;
			end
		end

		if (in_last) begin
			mode_d  = MODE_IDLE;
			conts_d = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			seq3_q  <= 1'b0;
			conts_q <= 2'd0;
		end else if (take) begin
			mode_q  <= mode_d;
			seq3_q  <= seq3_d;
			conts_q <= conts_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held0_q <= held0_d;
			held1_q <= held1_d;
		end
	end

	assign desc.nrep = nrep;
	assign desc.nlit = nlit;
	assign desc.lit  = lit;
	assign desc.last = in_last;
	assign push      = take && (nrep != 2'd0 || nlit != 2'd0 || in_last);

endmodule

`default_nettype wire

// ===== hdl/utf8_to_cesu8_sanitizer.sv =====
// top level: parser, skid stage and byte-serial output of the sanitized stream
`default_nettype none

// Turns a raw byte stream into valid CESU-8, one output byte per beat. Each input
// byte is decoded in the cycle it is accepted and yields 0 to 9 output bytes
// (an invalid byte yields one EF BF BD, i.e. 3 bytes); the output port sends one
// byte per cycle while out_ready is high. Bytes that only open a sequence yield
// no output work. A one-entry skid stage holds the next item's work, so in_ready
// is a register and the input side keeps moving while a result waits at the
// output, until the skid stage fills. When the final byte of a string produces
// nothing, one beat with has_byte low still marks the end of the string.
module utf8_to_cesu8_sanitizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       out_byte,
	output logic             has_byte,
	output logic             run_last,
	output logic             stream_last
);
	import usan_pkg::*;

	usan_desc_t  new_desc;
	logic        push;
	logic        in_acc;

	usan_desc_t  skid_q;
	logic        skid_valid_q;
	usan_desc_t  cur_q;
	logic        cur_valid_q;
	logic [1:0]  rep_left_q;
	logic [1:0]  phase_q;
	logic [1:0]  lit_pos_q;

	logic        fin;
	logic        out_fire;
	logic        cur_done;
	logic        cur_free;
	logic [7:0]  repl_byte;

	assign in_ready = !skid_valid_q;
	assign in_acc   = in_valid && in_ready;

	usan_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_acc),
		.in_byte (in_byte),
		.in_last (in_last),
		.desc    (new_desc),
		.push    (push)
	);

	always_comb begin
		unique case (phase_q)
			REPL_POS0: repl_byte = REPL_BYTE0;
			REPL_POS1: repl_byte = REPL_BYTE1;
			default:   repl_byte = REPL_BYTE2;
		endcase
	end

	always_comb begin
		if (rep_left_q != 2'd0) begin
			fin = (rep_left_q == 2'd1) && (phase_q == REPL_POS2) && (cur_q.nlit == 2'd0);
		end else begin
			fin = (cur_q.nlit == 2'd0) || (lit_pos_q == cur_q.nlit - 2'd1);
		end
	end

	assign out_valid   = cur_valid_q;
	assign has_byte    = (rep_left_q != 2'd0) || (cur_q.nlit != 2'd0);
	assign out_byte    = (rep_left_q != 2'd0) ? repl_byte :
	                     (has_byte ? cur_q.lit[lit_pos_q] : 8'd0);
	assign run_last    = fin;
	assign stream_last = fin && cur_q.last;

	assign out_fire = out_valid && out_ready;
	assign cur_done = out_fire && fin;
	assign cur_free = !cur_valid_q || cur_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
			cur_valid_q  <= 1'b0;
			rep_left_q   <= 2'd0;
			phase_q      <= REPL_POS0;
			lit_pos_q    <= 2'd0;
		end else if (skid_valid_q && cur_free) begin
			skid_valid_q <= 1'b0;
			cur_valid_q  <= 1'b1;
			rep_left_q   <= skid_q.nrep;
			phase_q      <= REPL_POS0;
			lit_pos_q    <= 2'd0;
		end else if (push && cur_free) begin
			cur_valid_q <= 1'b1;
			rep_left_q  <= new_desc.nrep;
			phase_q     <= REPL_POS0;
			lit_pos_q   <= 2'd0;
		end else begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
			if (cur_done) begin
				cur_valid_q <= 1'b0;
			end else if (out_fire) begin
				if (rep_left_q != 2'd0) begin
					if (phase_q == REPL_POS2) begin
						phase_q    <= REPL_POS0;
						rep_left_q <= rep_left_q - 2'd1;
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end else begin
					lit_pos_q <= lit_pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && cur_free) begin
			cur_q <= skid_q;
		end else if (push && cur_free) begin
			cur_q <= new_desc;
		end else if (push) begin
			skid_q <= new_desc;
		end
	end

	// skid stage only fills behind a busy output
	a_skid_behind_cur: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> cur_valid_q)
		else $error("skid entry without a current entry");

	a_empty_marker_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (run_last && stream_last))
		else $error("empty beat that does not end the string");

	a_stream_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stream_last) |-> run_last)
		else $error("string end inside a run");

	a_lit_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && rep_left_q == 2'd0 && has_byte) |-> (lit_pos_q < cur_q.nlit))
		else $error("literal position past the literal count");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (phase_q != 2'd3))
		else $error("replacement phase out of range");

endmodule

`default_nettype wire
